>>> hw/rtl/dst_pkg.sv
`default_nettype none

package dst_pkg;

  localparam int unsigned EntryW = 25;
  localparam int unsigned FormW  = 17;
  localparam int unsigned TagW   = 16;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned FillW  = 5;

  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  typedef struct packed {
    logic signed [EntryW-1:0] entry;
    logic signed [FormW-1:0]  form;
    logic [TagW-1:0]          tag;
    logic signed [ScoreW-1:0] score;
  } item_t;

  // scan state rippled from cell to cell, lowest index first
  typedef struct packed {
    logic live;
    logic found;
    logic raised;
    logic reject;
  } chain_t;

  typedef struct packed {
    logic upd_en;
    logic app_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/dst_cell.sv
`default_nettype none

module dst_cell #(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  logic                clk_i,
  input  dst_pkg::item_t      item_i,
  input  logic [CntW-1:0]     cnt_i,
  input  dst_pkg::cell_ctrl_t ctrl_i,
  input  dst_pkg::chain_t     chain_i,
  output dst_pkg::chain_t     chain_o
);
  import dst_pkg::*;

  localparam logic [CntW-1:0] MyIdx = CntW'(Idx);

  logic signed [EntryW-1:0] entry_q;
  logic signed [FormW-1:0]  form_q;
  logic [TagW-1:0]          tag_q;
  logic signed [ScoreW-1:0] score_q;

  logic stop_q, hit_q, less_q, rej_q;
  logic stop_d, hit_d, less_d, rej_d;
  logic coord, tag0, teq, dup;

  always_comb begin
    coord  = (cnt_i > MyIdx) && (entry_q == item_i.entry) && (form_q == item_i.form);
    tag0   = (tag_q == '0);
    teq    = (tag_q == item_i.tag);
    stop_d = coord && (tag0 || teq);
    hit_d  = stop_d && teq;
    less_d = $signed(score_q) < $signed(item_i.score);
    rej_d  = coord && ((item_i.tag == '0) || tag0 || teq);
  end

  always_ff @(posedge clk_i) begin
    stop_q <= stop_d;
    hit_q  <= hit_d;
    less_q <= less_d;
    rej_q  <= rej_d;
  end

  assign dup = chain_i.live && hit_q;

  always_comb begin
    chain_o.live   = chain_i.live && !stop_q;
    chain_o.found  = chain_i.found || dup;
    chain_o.raised = chain_i.raised || (dup && less_q);
    chain_o.reject = chain_i.reject || rej_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.app_en && (cnt_i == MyIdx)) begin
      entry_q <= item_i.entry;
      form_q  <= item_i.form;
      tag_q   <= item_i.tag;
      score_q <= item_i.score;
    end else if (ctrl_i.upd_en && dup && less_q) begin
      score_q <= item_i.score;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/dedup_score_table_top.sv
`default_nettype none

// Channel  Dir  Signals                          Payload
// s_axis   in   tvalid tready tdata[95:0] tuser  opcode, entry/form/tag/score
// m_axis   out  tvalid tready tdata[15:0]        flags, fill count, changed
//
// Each item is accepted, compared in every cell, then priority
// rippled along the cell chain with write-back into the result register.
// The next item is accepted the cycle after write-back, not before.
// Write-back waits while the result register is full and m_axis_tready is low.
// Reset empties the table and clears the changed mark; record cells keep data.
module dedup_score_table_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [24:0] entry_key, [41:25] form_key, [57:42] info_tag, [89:58] score_in
  input  logic [dst_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] accepted, [1] score_raised, [2] overflow, [7:3] fill_count, [8] changed_flag
  output logic [dst_pkg::OutDataW-1:0]  m_axis_tdata
);
  import dst_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(DEPTH);

  state_e     state_q, state_d;
  op_e        op_q;
  item_t      item_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic       dirty_q, dirty_d;
  logic       out_valid_q;
  logic       acc_q, raised_q, ovf_q;
  logic       acc_d, raised_d, ovf_d;
  logic       in_fire, out_take, fire;
  cell_ctrl_t ctrl;
  chain_t     links [DEPTH+1];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;
  assign fire     = (state_q == ST_UPD) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q         <= op_e'(s_axis_tuser);
      item_q.entry <= $signed(s_axis_tdata[24:0]);
      item_q.form  <= $signed(s_axis_tdata[41:25]);
      item_q.tag   <= s_axis_tdata[57:42];
      item_q.score <= $signed(s_axis_tdata[89:58]);
    end
  end

  assign links[0] = '{live: 1'b1, found: 1'b0, raised: 1'b0, reject: 1'b0};

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dst_cell #(
      .CntW (CntW),
      .Idx  (g)
    ) u_cell (
      .clk_i   (clk_i),
      .item_i  (item_q),
      .cnt_i   (cnt_q),
      .ctrl_i  (ctrl),
      .chain_i (links[g]),
      .chain_o (links[g+1])
    );
  end

  always_comb begin
    ctrl.upd_en = fire && (op_q == OP_ADD);
    ctrl.app_en = ctrl.upd_en && !links[DEPTH].found && (cnt_q != Full);
  end

  always_comb begin
    cnt_d    = cnt_q;
    dirty_d  = dirty_q;
    acc_d    = 1'b0;
    raised_d = 1'b0;
    ovf_d    = 1'b0;
    case (op_q)
      OP_ADD: begin
        if (links[DEPTH].found) begin
          raised_d = links[DEPTH].raised;
          dirty_d  = dirty_q || links[DEPTH].raised;
        end else if (cnt_q == Full) begin
          ovf_d = 1'b1;
        end else begin
          acc_d   = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          dirty_d = 1'b1;
        end
      end
      OP_QUERY: begin
        acc_d = !links[DEPTH].reject;
      end
      OP_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  if (fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      dirty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        cnt_q       <= cnt_d;
        dirty_q     <= dirty_d;
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_q    <= acc_d;
      raised_q <= raised_d;
      ovf_q    <= ovf_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, dirty_q, FillW'(cnt_q), ovf_q, raised_q, acc_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full) else $error("record count above depth");

  a_dirty_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(dirty_q)) else $error("changed mark dropped");

  a_acc_raise_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(acc_q && raised_q)) else $error("append and raise together");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ovf_q) |-> (cnt_q == Full)) else $error("overflow below depth");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.app_en |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("append lost count");

endmodule

`default_nettype wire

>>> dv/dedup_score_table_top_tb.sv
`timescale 1ns / 100ps

module dedup_score_table_top_tb;
  import dst_pkg::*;

  localparam int TblDepth  = 16;
  localparam int RandItems = 1850;
  localparam int CycLimit  = 1000000;
  localparam int TailWait  = 24;

  typedef struct packed {
    logic                     drain;
    op_e                      op;
    logic signed [EntryW-1:0] entry;
    logic signed [FormW-1:0]  form;
    logic [TagW-1:0]          tag;
    logic signed [ScoreW-1:0] score;
  } tbl_req_t;

  // field order matches m_axis_tdata[8:0]
  typedef struct packed {
    logic             changed;
    logic [FillW-1:0] fill;
    logic             ovf;
    logic             raised;
    logic             acc;
  } tbl_resp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = OP_NONE;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  tbl_req_t  req_q[$];
  tbl_resp_t resp_exp_q[$];

  logic signed [EntryW-1:0] shadow_entry [TblDepth];
  logic signed [FormW-1:0]  shadow_form  [TblDepth];
  logic [TagW-1:0]          shadow_tag   [TblDepth];
  logic signed [ScoreW-1:0] shadow_score [TblDepth];
  int   shadow_cnt   = 0;
  logic shadow_dirty = 1'b0;

  int err_cnt   = 0;
  int sent_cnt  = 0;
  int cyc_cnt   = 0;
  int tx_gap    = 0;
  int rx_gap    = 0;
  int hold_left = 0;
  int hold_step = 0;
  int calm_left [2] = '{0, 0};

  dedup_score_table_top #(
    .DEPTH(TblDepth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic tbl_resp_t score_table_step(input tbl_req_t it);
    tbl_resp_t r;
    int        i;
    int        hit;
    bit        found;
    bit        stop;
    r     = '0;
    hit   = 0;
    found = 1'b0;
    stop  = 1'b0;
    case (it.op)
      OP_ADD: begin
        for (i = 0; i < shadow_cnt; i++) begin
          if (!stop && shadow_entry[i] == it.entry && shadow_form[i] == it.form) begin
            if (it.tag == '0) begin
              if (shadow_tag[i] == '0) begin
                found = 1'b1;
                hit   = i;
                stop  = 1'b1;
              end
            end else if (shadow_tag[i] == '0) begin
              stop = 1'b1;
            end else if (shadow_tag[i] == it.tag) begin
              found = 1'b1;
              hit   = i;
              stop  = 1'b1;
            end
          end
        end
        if (found) begin
          if (it.score > shadow_score[hit]) begin
            shadow_score[hit] = it.score;
            shadow_dirty      = 1'b1;
            r.raised          = 1'b1;
          end
        end else if (shadow_cnt >= TblDepth) begin
          r.ovf = 1'b1;
        end else begin
          shadow_entry[shadow_cnt] = it.entry;
          shadow_form[shadow_cnt]  = it.form;
          shadow_tag[shadow_cnt]   = it.tag;
          shadow_score[shadow_cnt] = it.score;
          shadow_cnt++;
          shadow_dirty = 1'b1;
          r.acc        = 1'b1;
        end
      end
      OP_QUERY: begin
        r.acc = 1'b1;
        for (i = 0; i < shadow_cnt; i++) begin
          if (!stop && shadow_entry[i] == it.entry && shadow_form[i] == it.form) begin
            if (it.tag == '0 || shadow_tag[i] == '0 || shadow_tag[i] == it.tag) begin
              r.acc = 1'b0;
              stop  = 1'b1;
            end
          end
        end
      end
      OP_CLEAR: shadow_cnt = 0;
      default: ;
    endcase
    r.fill    = shadow_cnt[FillW-1:0];
    r.changed = shadow_dirty;
    return r;
  endfunction

  // side 0: sender, side 1: receiver
  function automatic int pick_gap(input int side);
    int r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 15) begin
      calm_left[side] = $urandom_range(20, 80);
      return 0;
    end
    if (r < 500) return 0;
    if (r < 850) return $urandom_range(1, 3);
    if (r < 970) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_req(input op_e op, input logic [EntryW-1:0] e,
                          input logic [FormW-1:0] f, input logic [TagW-1:0] t,
                          input logic [ScoreW-1:0] s);
    tbl_req_t it;
    it.drain = 1'b0;
    it.op    = op;
    it.entry = e;
    it.form  = f;
    it.tag   = t;
    it.score = s;
    req_q.insert(req_q.size(), it);
  endtask

  task automatic push_pause();
    tbl_req_t it;
    it       = '0;
    it.drain = 1'b1;
    req_q.insert(req_q.size(), it);
  endtask

  // sender
  always @(posedge clk_i) begin
    tbl_req_t  cur;
    tbl_resp_t nxt;
    logic      vld;
    if (rst_ni) begin
      vld = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        cur = req_q.pop_front();
        nxt = score_table_step(cur);
        resp_exp_q.insert(resp_exp_q.size(), nxt);
        sent_cnt++;
        vld    = 1'b0;
        tx_gap = pick_gap(0);
      end
      if (!vld) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (req_q.size() > 0) begin
          if (req_q[0].drain) begin
            if (resp_exp_q.size() == 0) void'(req_q.pop_front());
          end else begin
            vld = 1'b1;
            s_axis_tdata <= {6'd0, req_q[0].score, req_q[0].tag, req_q[0].form,
                             req_q[0].entry};
            s_axis_tuser <= req_q[0].op;
          end
        end
      end
      s_axis_tvalid <= vld;
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    tbl_resp_t got;
    tbl_resp_t want;
    logic      rdy;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[8:0];
        if (resp_exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected item: tdata=%h", m_axis_tdata);
        end else begin
          want = resp_exp_q.pop_front();
          if (got.acc !== want.acc || got.raised !== want.raised || got.ovf !== want.ovf ||
              got.fill !== want.fill || got.changed !== want.changed) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch: exp acc=%0d raised=%0d ovf=%0d fill=%0d chg=%0d",
                       want.acc, want.raised, want.ovf, want.fill, want.changed);
              $display("          got acc=%0d raised=%0d ovf=%0d fill=%0d chg=%0d",
                       got.acc, got.raised, got.ovf, got.fill, got.changed);
            end
          end
        end
        rx_gap = pick_gap(1);
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_step < 2 && sent_cnt >= 400 + 800 * hold_step) begin
        hold_left = 300;
        hold_step++;
        rdy = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CycLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [EntryW-1:0] pool_e [6];
    logic [FormW-1:0]  pool_f [6];
    logic [EntryW-1:0] e;
    logic [FormW-1:0]  f;
    logic [TagW-1:0]   t;
    logic [ScoreW-1:0] s;
    op_e               op;
    int                k;
    int                r;
    int                seg_left;

    // directed
    push_req(OP_QUERY, '1, '1, 16'd0, 32'd0);
    push_req(OP_ADD, '1, '1, 16'd0, 32'h8000_0000);
    push_req(OP_ADD, '1, '1, 16'd0, 32'h7FFF_FFFF);
    push_req(OP_ADD, '1, '1, 16'd0, 32'h7FFF_FFFF);
    push_req(OP_ADD, '1, '1, 16'hFFFF, 32'd3);
    push_req(OP_ADD, '0, '0, 16'd5, 32'd0);
    push_req(OP_ADD, '0, '0, 16'd5, 32'hFFFF_FFFF);
    push_req(OP_ADD, '0, '0, 16'd5, 32'd1);
    push_req(OP_ADD, '0, '0, 16'd6, 32'd9);
    push_req(OP_ADD, '0, '0, 16'd0, 32'd9);
    push_req(OP_QUERY, '0, '0, 16'd7, 32'd0);
    push_req(OP_QUERY, 25'h0FF_FFFF, 17'h0FFFF, 16'd1, 32'd0);
    push_req(OP_ADD, 25'h0FF_FFFF, 17'h0FFFF, 16'hAAAA, 32'h5555_5555);
    push_req(OP_QUERY, '1, '1, 16'd0, 32'd0);
    push_req(OP_NONE, '1, '1, '1, '1);
    for (k = 0; k < 10; k++) push_req(OP_ADD, EntryW'(100 + k), '0, 16'd0, 32'd7);
    push_req(OP_ADD, 25'd200, '0, 16'd0, 32'd1);
    push_req(OP_ADD, '0, '0, 16'd5, 32'h7FFF_FFFF);
    push_req(OP_QUERY, 25'd300, '0, 16'd2, 32'd0);
    push_req(OP_CLEAR, '0, '0, 16'd0, 32'd0);
    push_req(OP_QUERY, '0, '0, 16'd0, 32'd0);
    push_req(OP_ADD, '0, '0, 16'd0, 32'd0);
    push_pause();

    pool_e[0] = '1;
    pool_f[0] = '1;
    pool_e[1] = '0;
    pool_f[1] = '0;
    pool_e[2] = 25'h0FF_FFFF;
    pool_f[2] = 17'h0FFFF;
    pool_e[3] = '0;
    pool_f[3] = 17'd1;
    for (k = 4; k < 6; k++) begin
      pool_e[k] = EntryW'($urandom_range(0, 24'hFF_FFFF));
      pool_f[k] = FormW'($urandom_range(0, 16'hFFFF));
    end

    seg_left = 0;
    for (k = 0; k < RandItems; k++) begin
      if (seg_left == 0) begin
        push_req(OP_CLEAR, EntryW'($urandom), FormW'($urandom), TagW'($urandom), $urandom);
        seg_left = $urandom_range(20, 60);
      end
      seg_left--;
      r = $urandom_range(0, 99);
      if (r < 62) op = OP_ADD;
      else if (r < 95) op = OP_QUERY;
      else if (r < 99) op = OP_CLEAR;
      else op = OP_NONE;
      if ($urandom_range(0, 99) < 85) begin
        r = $urandom_range(0, 5);
        e = pool_e[r];
        f = pool_f[r];
      end else begin
        e = ($urandom_range(0, 9) == 0) ? '1 : EntryW'($urandom_range(0, 24'hFF_FFFF));
        f = ($urandom_range(0, 9) == 0) ? '1 : FormW'($urandom_range(0, 16'hFFFF));
      end
      case ($urandom_range(0, 7))
        0, 1:    t = 16'd0;
        2:       t = 16'd1;
        3:       t = 16'd2;
        4:       t = 16'd3;
        5:       t = 16'hFFFF;
        default: t = TagW'($urandom_range(0, 16'hFFFF));
      endcase
      case ($urandom_range(0, 19))
        0:       s = 32'h8000_0000;
        1:       s = 32'h7FFF_FFFF;
        2:       s = 32'd0;
        3:       s = 32'hFFFF_FFFF;
        default: s = $urandom;
      endcase
      push_req(op, e, f, t, s);
      if (k == RandItems / 2) push_pause();
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (req_q.size() != 0 || resp_exp_q.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
    if (err_cnt == 0 && resp_exp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
